@@ hw/rtl/jsv_pkg.sv @@
// Shared types and constants for the JSON syntax validator.
// Holds the classified byte beat that travels from the front end to the parser.
// No dependencies.
package jsv_pkg;

  localparam int DEFAULT_MAX_NESTING = 256;
  localparam int QUEUE_DEPTH         = 4;

  // Configuration register indexes.
  localparam logic REG_DEPTH_LIMIT         = 1'b0;
  localparam logic REG_NUMBER_LENGTH_LIMIT = 1'b1;

  localparam logic [8:0] DEPTH_LIMIT_RESET = 9'd256;
  localparam logic [7:0] NUM_LIMIT_RESET   = 8'd64;

  typedef struct packed {
    logic is_ws;
    logic is_digit;
    logic is_quote;
    logic is_lbrace;
    logic is_rbrace;
    logic is_lbrack;
    logic is_rbrack;
    logic is_comma;
    logic is_colon;
    logic is_bslash;
    logic is_minus;
    logic is_plus;
    logic is_dot;
    logic is_exp;
    logic is_esc_simple;
    logic is_u;
    logic is_n;
    logic is_t;
    logic is_f;
  } class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    class_t     cls;
  } item_t;

endpackage

@@ hw/rtl/jsv_front.sv @@
// Front end of the JSON syntax validator: takes input bytes and classifies them.
// Registers one classified beat for the queue. Depends on jsv_pkg.
module jsv_front
  import jsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       push_valid,
  input  logic       push_ready,
  output item_t      push_item
);

  function automatic class_t classify(input logic [7:0] b);
    class_t k;
    k.is_ws         = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    k.is_digit      = (b >= 8'h30) && (b <= 8'h39);
    k.is_quote      = (b == 8'h22);
    k.is_lbrace     = (b == 8'h7B);
    k.is_rbrace     = (b == 8'h7D);
    k.is_lbrack     = (b == 8'h5B);
    k.is_rbrack     = (b == 8'h5D);
    k.is_comma      = (b == 8'h2C);
    k.is_colon      = (b == 8'h3A);
    k.is_bslash     = (b == 8'h5C);
    k.is_minus      = (b == 8'h2D);
    k.is_plus       = (b == 8'h2B);
    k.is_dot        = (b == 8'h2E);
    k.is_exp        = (b == 8'h65) || (b == 8'h45);
    k.is_esc_simple = (b == 8'h22) || (b == 8'h5C) || (b == 8'h2F) || (b == 8'h62) ||
                      (b == 8'h66) || (b == 8'h6E) || (b == 8'h72) || (b == 8'h74);
    k.is_u          = (b == 8'h75);
    k.is_n          = (b == 8'h6E);
    k.is_t          = (b == 8'h74);
    k.is_f          = (b == 8'h66);
    return k;
  endfunction

  logic  held;
  item_t item;

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data_byte <= data_byte;
      item.last      <= last;
      item.cls       <= classify(data_byte);
    end
  end

endmodule

@@ hw/rtl/jsv_queue.sv @@
// Short queue of classified beats between the front end and the parser.
// Lets either side stall without stopping the other. Depends on jsv_pkg.
module jsv_queue
  import jsv_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count != CW'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/jsv_back.sv @@
// Parser back end of the JSON syntax validator: mode machine, container stack,
// configuration registers and the registered result. Depends on jsv_pkg.
module jsv_back
  import jsv_pkg::*;
#(
  parameter int MAX_NESTING = DEFAULT_MAX_NESTING
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       q_valid,
  output logic       q_ready,
  input  item_t      q_item,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       accepted,
  output logic [2:0] root_kind
);

  localparam int DW = $clog2(MAX_NESTING + 1);
  localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam int LW = (DW > 9) ? DW : 9;

  localparam logic [2:0] ROOT_NULL   = 3'd0;
  localparam logic [2:0] ROOT_BOOL   = 3'd1;
  localparam logic [2:0] ROOT_INT    = 3'd2;
  localparam logic [2:0] ROOT_REAL   = 3'd3;
  localparam logic [2:0] ROOT_STRING = 3'd4;
  localparam logic [2:0] ROOT_ARRAY  = 3'd5;
  localparam logic [2:0] ROOT_OBJECT = 3'd6;

  localparam logic [2:0] NUM_IDLE       = 3'd0;
  localparam logic [2:0] NUM_INT        = 3'd1;
  localparam logic [2:0] NUM_FRAC       = 3'd2;
  localparam logic [2:0] NUM_EXP        = 3'd3;
  localparam logic [2:0] NUM_EXP_DIGITS = 3'd4;

  localparam logic [3:0] LIT_NULL_START  = 4'd1;
  localparam logic [3:0] LIT_TRUE_START  = 4'd5;
  localparam logic [3:0] LIT_FALSE_START = 4'd9;
  localparam logic [3:0] LIT_NULL_END    = 4'd4;
  localparam logic [3:0] LIT_TRUE_END    = 4'd8;
  localparam logic [3:0] LIT_FALSE_END   = 4'd13;

  typedef enum logic [10:0] {
    M_VALUE     = 11'b000_0000_0001,
    M_ARR_FIRST = 11'b000_0000_0010,
    M_OBJ_FIRST = 11'b000_0000_0100,
    M_KEY       = 11'b000_0000_1000,
    M_COLON     = 11'b000_0001_0000,
    M_AFTER     = 11'b000_0010_0000,
    M_STR       = 11'b000_0100_0000,
    M_ESC       = 11'b000_1000_0000,
    M_USKIP     = 11'b001_0000_0000,
    M_LIT       = 11'b010_0000_0000,
    M_NUM       = 11'b100_0000_0000
  } mode_t;

  // Letters of "null", "true" and "false" laid end to end.
  function automatic logic [7:0] lit_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h6E;
      4'd1:    ch = 8'h75;
      4'd2:    ch = 8'h6C;
      4'd3:    ch = 8'h6C;
      4'd4:    ch = 8'h74;
      4'd5:    ch = 8'h72;
      4'd6:    ch = 8'h75;
      4'd7:    ch = 8'h65;
      4'd8:    ch = 8'h66;
      4'd9:    ch = 8'h61;
      4'd10:   ch = 8'h6C;
      4'd11:   ch = 8'h73;
      4'd12:   ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  logic [8:0]    depth_limit;
  logic [7:0]    number_length_limit;

  mode_t         mode, mode_next, eff_mode;
  logic [DW-1:0] depth, depth_next, depth_dec;
  logic [3:0]    lit, lit_next, lit_inc;
  logic [2:0]    phase, phase_next, num_phase;
  logic [7:0]    num_len, num_len_next, cnt_base;
  logic [2:0]    esc, esc_next, esc_dec;
  logic          is_key, is_key_next;
  logic [2:0]    root, root_next;
  logic          failed, failed_next;

  logic          pop;
  logic          num_take;
  logic          do_start;
  logic          do_count;
  logic          push;
  logic          push_kind;
  logic          ok;
  class_t        c;
  logic [7:0]    b;

  logic          kinds [MAX_NESTING];
  logic          top_rd;
  logic          top_byp;
  logic          top_byp_val;
  logic          top_kind;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign q_ready  = !q_item.last || !out_valid || out_ready;
  assign pop      = q_valid && q_ready;
  assign c        = q_item.cls;
  assign b        = q_item.data_byte;
  assign top_kind = top_byp ? top_byp_val : top_rd;
  assign wr_addr  = depth[AW-1:0];
  assign depth_dec = depth_next - DW'(1);
  assign rd_addr  = depth_dec[AW-1:0];
  assign lit_inc  = lit + 4'd1;
  assign esc_dec  = (esc != 3'd0) ? esc - 3'd1 : esc;

  always_comb begin
    num_phase = NUM_IDLE;
    case (phase)
      NUM_INT: begin
        if (c.is_digit) num_phase = NUM_INT;
        else if (c.is_dot) num_phase = NUM_FRAC;
        else if (c.is_exp) num_phase = NUM_EXP;
      end
      NUM_FRAC: begin
        if (c.is_digit) num_phase = NUM_FRAC;
        else if (c.is_exp) num_phase = NUM_EXP;
      end
      NUM_EXP: begin
        if (c.is_plus || c.is_minus || c.is_digit) num_phase = NUM_EXP_DIGITS;
      end
      NUM_EXP_DIGITS: begin
        if (c.is_digit) num_phase = NUM_EXP_DIGITS;
      end
      default: num_phase = NUM_IDLE;
    endcase
  end

  always_comb begin
    mode_next    = mode;
    depth_next   = depth;
    lit_next     = lit;
    phase_next   = phase;
    num_len_next = num_len;
    esc_next     = esc;
    is_key_next  = is_key;
    root_next    = root;
    failed_next  = failed;
    eff_mode     = mode;
    num_take     = 1'b0;
    do_start     = 1'b0;
    do_count     = 1'b0;
    cnt_base     = num_len;
    push         = 1'b0;
    push_kind    = 1'b0;
    ok           = 1'b0;

    if (pop && !failed) begin
      // A byte that does not extend a number ends it and is parsed again as
      // the byte after a complete value.
      if (mode == M_NUM) begin
        if (num_phase != NUM_IDLE) begin
          num_take   = 1'b1;
          phase_next = num_phase;
          do_count   = 1'b1;
          if ((num_phase == NUM_FRAC || num_phase == NUM_EXP) && depth == '0) begin
            root_next = ROOT_REAL;
          end
        end else begin
          phase_next = NUM_IDLE;
          eff_mode   = M_AFTER;
          mode_next  = M_AFTER;
        end
      end

      if (!num_take) begin
        case (eff_mode)
          M_VALUE: begin
            if (!c.is_ws) do_start = 1'b1;
          end
          M_ARR_FIRST: begin
            if (c.is_rbrack) begin
              depth_next = depth - DW'(1);
              mode_next  = M_AFTER;
            end else if (!c.is_ws) begin
              do_start = 1'b1;
            end
          end
          M_OBJ_FIRST, M_KEY: begin
            if (!c.is_ws) begin
              if (c.is_rbrace && eff_mode == M_OBJ_FIRST) begin
                depth_next = depth - DW'(1);
                mode_next  = M_AFTER;
              end else if (c.is_quote) begin
                is_key_next = 1'b1;
                mode_next   = M_STR;
              end else begin
                failed_next = 1'b1;
              end
            end
          end
          M_COLON: begin
            if (c.is_colon) mode_next = M_VALUE;
            else if (!c.is_ws) failed_next = 1'b1;
          end
          M_AFTER: begin
            if (!c.is_ws) begin
              if (depth == '0) begin
                failed_next = 1'b1;
              end else if (c.is_comma) begin
                mode_next = top_kind ? M_KEY : M_VALUE;
              end else if (top_kind ? c.is_rbrace : c.is_rbrack) begin
                depth_next = depth - DW'(1);
              end else begin
                failed_next = 1'b1;
              end
            end
          end
          M_STR: begin
            if (c.is_quote) begin
              mode_next   = is_key ? M_COLON : M_AFTER;
              is_key_next = 1'b0;
            end else if (c.is_bslash) begin
              mode_next = M_ESC;
            end
          end
          M_ESC: begin
            if (c.is_esc_simple) begin
              mode_next = M_STR;
            end else if (c.is_u) begin
              esc_next  = 3'd4;
              mode_next = M_USKIP;
            end else begin
              failed_next = 1'b1;
            end
          end
          M_USKIP: begin
            esc_next = esc_dec;
            if (esc_dec == 3'd0) mode_next = M_STR;
          end
          M_LIT: begin
            if (lit < LIT_FALSE_END && b == lit_char(lit)) begin
              if (lit_inc == LIT_NULL_END || lit_inc == LIT_TRUE_END ||
                  lit_inc == LIT_FALSE_END) begin
                lit_next  = 4'd0;
                mode_next = M_AFTER;
              end else begin
                lit_next = lit_inc;
              end
            end else begin
              failed_next = 1'b1;
            end
          end
          default: failed_next = 1'b1;
        endcase
      end
    end

    if (do_start) begin
      if (c.is_quote) begin
        if (depth == '0) root_next = ROOT_STRING;
        is_key_next = 1'b0;
        mode_next   = M_STR;
      end else if (c.is_lbrace || c.is_lbrack) begin
        if (LW'(depth) >= LW'(depth_limit) || depth >= DW'(MAX_NESTING)) begin
          failed_next = 1'b1;
        end else begin
          if (depth == '0) root_next = c.is_lbrace ? ROOT_OBJECT : ROOT_ARRAY;
          push       = 1'b1;
          push_kind  = c.is_lbrace;
          depth_next = depth + DW'(1);
          mode_next  = c.is_lbrace ? M_OBJ_FIRST : M_ARR_FIRST;
        end
      end else if (c.is_n || c.is_t || c.is_f) begin
        if (depth == '0) root_next = c.is_n ? ROOT_NULL : ROOT_BOOL;
        lit_next  = c.is_n ? LIT_NULL_START : (c.is_t ? LIT_TRUE_START : LIT_FALSE_START);
        mode_next = M_LIT;
      end else if (c.is_minus || c.is_digit) begin
        if (depth == '0) root_next = ROOT_INT;
        phase_next = NUM_INT;
        cnt_base   = 8'd0;
        do_count   = 1'b1;
        mode_next  = M_NUM;
      end else begin
        failed_next = 1'b1;
      end
    end

    // The length saturates and is checked on every character it takes.
    if (do_count) begin
      num_len_next = (cnt_base != 8'hFF) ? cnt_base + 8'd1 : cnt_base;
      if (num_len_next >= number_length_limit) failed_next = 1'b1;
    end

    if (pop && q_item.last) begin
      ok = !failed_next && depth_next == '0 && (mode_next == M_AFTER || mode_next == M_NUM);
      mode_next    = M_VALUE;
      depth_next   = '0;
      lit_next     = 4'd0;
      phase_next   = NUM_IDLE;
      num_len_next = 8'd0;
      esc_next     = 3'd0;
      is_key_next  = 1'b0;
      failed_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit         <= DEPTH_LIMIT_RESET;
      number_length_limit <= NUM_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEPTH_LIMIT:         depth_limit <= cfg_data;
        REG_NUMBER_LENGTH_LIMIT: number_length_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_VALUE;
      depth   <= '0;
      lit     <= 4'd0;
      phase   <= NUM_IDLE;
      num_len <= 8'd0;
      esc     <= 3'd0;
      is_key  <= 1'b0;
      root    <= ROOT_NULL;
      failed  <= 1'b0;
    end else begin
      mode    <= mode_next;
      depth   <= depth_next;
      lit     <= lit_next;
      phase   <= phase_next;
      num_len <= num_len_next;
      esc     <= esc_next;
      is_key  <= is_key_next;
      root    <= (pop && q_item.last) ? ROOT_NULL : root_next;
      failed  <= failed_next;
    end
  end

  // The entry below the next depth is read every cycle so the innermost
  // container kind is ready for the following beat; a push in the same
  // cycle is forwarded around the memory.
  always_ff @(posedge clk) begin
    if (push) begin
      kinds[wr_addr] <= push_kind;
    end
    top_rd      <= kinds[rd_addr];
    top_byp     <= push && (wr_addr == rd_addr);
    top_byp_val <= push_kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && q_item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.last) begin
      accepted  <= ok;
      root_kind <= ok ? root_next : ROOT_NULL;
    end
  end

endmodule

@@ hw/rtl/json_syntax_validator.sv @@
// Streaming JSON syntax validator: one document in as bytes, one verdict out.
// It takes one byte per clock cycle with no gaps between documents, but an
// untaken verdict stalls the next document's last byte. A byte passes a
// classifying input register, a four-beat queue and the parser, whose mode
// register and container stack are updated once per byte; the parser registers
// a verdict on a document's last byte. The stack, a memory of MAX_NESTING
// one-bit entries with one write and one registered read per cycle, needs no
// clearing after reset. The user must write the depth and number length limits
// through the configuration port while no document is in flight; this is not
// enforced. Top level; depends on jsv_pkg, jsv_front, jsv_queue and jsv_back.
module json_syntax_validator
  import jsv_pkg::*;
#(
  parameter int MAX_NESTING = DEFAULT_MAX_NESTING
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       accepted,
  output logic [2:0] root_kind
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  jsv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last       (last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  jsv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  jsv_back #(
    .MAX_NESTING (MAX_NESTING)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .accepted   (accepted),
    .root_kind  (root_kind)
  );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for json_syntax_validator: streams JSON documents byte by byte
// and compares every verdict against a cycle-free syntax predictor kept in this file.
// Depends on jsv_pkg and the json_syntax_validator RTL only.
module testbench;
  import jsv_pkg::*;

  localparam int NEST_BOUND       = DEFAULT_MAX_NESTING;
  localparam int SETTLE_CYCLES    = 8;
  localparam int SHOWN_MISMATCHES = 10;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [8*13-1:0] LITERAL_TEXT = "nulltruefalse";

  localparam int NUM_NONE       = 0;
  localparam int NUM_INT        = 1;
  localparam int NUM_FRAC       = 2;
  localparam int NUM_EXP        = 3;
  localparam int NUM_EXP_DIGITS = 4;

  typedef enum logic [3:0] {
    PM_VALUE, PM_ARR_FIRST, PM_OBJ_FIRST, PM_KEY, PM_COLON, PM_AFTER,
    PM_STR, PM_ESC, PM_USKIP, PM_LIT, PM_NUM
  } parse_mode_e;

  typedef enum logic [2:0] {
    KIND_NULL, KIND_BOOL, KIND_INT, KIND_REAL, KIND_STRING, KIND_ARRAY, KIND_OBJECT
  } root_kind_e;

  typedef struct packed {
    logic       acc;
    logic [2:0] kind;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_DEPTH_LIMIT;
  logic [8:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = '0;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       accepted;
  logic [2:0] root_kind;

  json_syntax_validator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .accepted  (accepted),
    .root_kind (root_kind)
  );

  always #5 clk = ~clk;

  // Predicted syntax state and register copies.
  parse_mode_e pmode = PM_VALUE;
  bit          open_kinds [NEST_BOUND];
  int          open_depth = 0;
  int          lit_pos = 0;
  int          num_phase = NUM_NONE;
  logic [7:0]  num_len = '0;
  int          hex_left = 0;
  bit          in_key = 1'b0;
  root_kind_e  root_seen = KIND_NULL;
  bit          doc_failed = 1'b0;
  logic [8:0]  depth_limit = DEPTH_LIMIT_RESET;
  logic [7:0]  num_limit = NUM_LIMIT_RESET;

  verdict_t    verdicts_due [$];
  logic [7:0]  doc_text [$];
  bit          gen_is_obj [$];
  int          gen_left [$];
  bit          gen_first [$];

  int          error_count = 0;
  int          bytes_sent = 0;
  int          docs_sent = 0;
  int          hold_left = 0;
  bit          sender_calm = 1'b0;
  bit          sink_calm = 1'b0;

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_simple_escape(logic [7:0] c);
    case (c)
      CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_doc();
    pmode = PM_VALUE;
    open_depth = 0;
    lit_pos = 0;
    num_phase = NUM_NONE;
    num_len = '0;
    hex_left = 0;
    in_key = 1'b0;
    root_seen = KIND_NULL;
    doc_failed = 1'b0;
  endfunction

  // The length check is made on every character, so a limit of zero fails at once.
  function automatic void count_num_char();
    if (num_len < 8'd255) num_len = num_len + 8'd1;
    if (num_len >= num_limit) doc_failed = 1'b1;
  endfunction

  function automatic void open_container(bit is_obj);
    if (open_depth >= depth_limit || open_depth >= NEST_BOUND) begin
      doc_failed = 1'b1;
      return;
    end
    if (open_depth == 0) root_seen = is_obj ? KIND_OBJECT : KIND_ARRAY;
    open_kinds[open_depth] = is_obj;
    open_depth++;
    pmode = is_obj ? PM_OBJ_FIRST : PM_ARR_FIRST;
  endfunction

  function automatic void start_value(logic [7:0] c);
    bit at_root;
    at_root = (open_depth == 0);
    if (c == CH_QUOTE) begin
      if (at_root) root_seen = KIND_STRING;
      in_key = 1'b0;
      pmode = PM_STR;
    end else if (c == "{") begin
      open_container(1'b1);
    end else if (c == "[") begin
      open_container(1'b0);
    end else if (c == "n" || c == "t" || c == "f") begin
      if (at_root) root_seen = (c == "n") ? KIND_NULL : KIND_BOOL;
      lit_pos = (c == "n") ? 1 : (c == "t") ? 5 : 9;
      pmode = PM_LIT;
    end else if (c == "-" || is_digit(c)) begin
      if (at_root) root_seen = KIND_INT;
      num_phase = NUM_INT;
      num_len = '0;
      count_num_char();
      pmode = PM_NUM;
    end else begin
      doc_failed = 1'b1;
    end
  endfunction

  function automatic bit number_take(logic [7:0] c);
    int nxt;
    nxt = NUM_NONE;
    case (num_phase)
      NUM_INT: begin
        if (is_digit(c)) nxt = NUM_INT;
        else if (c == ".") nxt = NUM_FRAC;
        else if (c == "e" || c == "E") nxt = NUM_EXP;
      end
      NUM_FRAC: begin
        if (is_digit(c)) nxt = NUM_FRAC;
        else if (c == "e" || c == "E") nxt = NUM_EXP;
      end
      NUM_EXP: begin
        if (c == "+" || c == "-" || is_digit(c)) nxt = NUM_EXP_DIGITS;
      end
      NUM_EXP_DIGITS: begin
        if (is_digit(c)) nxt = NUM_EXP_DIGITS;
      end
      default: nxt = NUM_NONE;
    endcase
    if (nxt == NUM_NONE) return 1'b0;
    if ((nxt == NUM_FRAC || nxt == NUM_EXP) && open_depth == 0) root_seen = KIND_REAL;
    num_phase = nxt;
    count_num_char();
    return 1'b1;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    // A byte that does not extend a number ends it and is then parsed as usual.
    if (pmode == PM_NUM) begin
      if (number_take(c)) return;
      num_phase = NUM_NONE;
      pmode = PM_AFTER;
    end
    case (pmode)
      PM_VALUE: begin
        if (!is_space(c)) start_value(c);
      end
      PM_ARR_FIRST: begin
        if (!is_space(c)) begin
          if (c == "]") begin
            open_depth--;
            pmode = PM_AFTER;
          end else begin
            start_value(c);
          end
        end
      end
      PM_OBJ_FIRST, PM_KEY: begin
        if (!is_space(c)) begin
          if (c == "}" && pmode == PM_OBJ_FIRST) begin
            open_depth--;
            pmode = PM_AFTER;
          end else if (c == CH_QUOTE) begin
            in_key = 1'b1;
            pmode = PM_STR;
          end else begin
            doc_failed = 1'b1;
          end
        end
      end
      PM_COLON: begin
        if (!is_space(c)) begin
          if (c == ":") pmode = PM_VALUE;
          else doc_failed = 1'b1;
        end
      end
      PM_AFTER: begin
        if (!is_space(c)) begin
          if (open_depth == 0) begin
            doc_failed = 1'b1;
          end else if (c == ",") begin
            pmode = open_kinds[open_depth-1] ? PM_KEY : PM_VALUE;
          end else if (c == (open_kinds[open_depth-1] ? 8'h7D : 8'h5D)) begin
            open_depth--;
          end else begin
            doc_failed = 1'b1;
          end
        end
      end
      PM_STR: begin
        if (c == CH_QUOTE) begin
          pmode = in_key ? PM_COLON : PM_AFTER;
          in_key = 1'b0;
        end else if (c == CH_BSLASH) begin
          pmode = PM_ESC;
        end
      end
      PM_ESC: begin
        if (is_simple_escape(c)) begin
          pmode = PM_STR;
        end else if (c == "u") begin
          hex_left = 4;
          pmode = PM_USKIP;
        end else begin
          doc_failed = 1'b1;
        end
      end
      PM_USKIP: begin
        if (hex_left > 0) hex_left--;
        if (hex_left == 0) pmode = PM_STR;
      end
      PM_LIT: begin
        if (lit_pos < 13 && c == LITERAL_TEXT[8*(12-lit_pos) +: 8]) begin
          lit_pos++;
          if (lit_pos == 4 || lit_pos == 8 || lit_pos == 13) begin
            lit_pos = 0;
            pmode = PM_AFTER;
          end
        end else begin
          doc_failed = 1'b1;
        end
      end
      default: doc_failed = 1'b1;
    endcase
  endfunction

  // Advances the predicted syntax state by one accepted byte; the final byte of a
  // document queues its verdict.
  function automatic void track_byte(logic [7:0] c, logic lst);
    verdict_t v;
    bit ok;
    if (!doc_failed) parse_byte(c);
    if (lst) begin
      ok = !doc_failed && open_depth == 0 && (pmode == PM_AFTER || pmode == PM_NUM);
      v.acc = ok;
      v.kind = ok ? root_seen : KIND_NULL;
      verdicts_due.push_back(v);
      clear_doc();
    end
  endfunction

  function automatic void check_verdict(logic acc, logic [2:0] kind);
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      if (error_count < SHOWN_MISMATCHES)
        $display("%0t: verdict with none outstanding: accepted=%0d root_kind=%0d",
                 $time, acc, kind);
      error_count++;
      return;
    end
    want = verdicts_due.pop_front();
    if (acc !== want.acc || kind !== want.kind) begin
      if (error_count < SHOWN_MISMATCHES)
        $display("%0t: verdict mismatch: expected accepted=%0d root_kind=%0d, got %0d %0d",
                 $time, want.acc, want.kind, acc, kind);
      error_count++;
    end
  endfunction

  // Receiver: random stalls, a calm mode and a counted hold-off.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_verdict(accepted, root_kind);
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= sink_calm || ($urandom_range(99) >= 16);
    end
  end

  // Document text builders.
  function automatic void put(logic [7:0] b);
    doc_text.push_back(b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) doc_text.push_back(s[i]);
  endfunction

  function automatic void put_ws();
    int k;
    if ($urandom_range(3) == 0) begin
      k = $urandom_range(3);
      put(k == 0 ? 8'h20 : k == 1 ? 8'h09 : k == 2 ? 8'h0A : 8'h0D);
    end
  endfunction

  function automatic void put_digits(int n);
    repeat (n) put(8'(8'h30 + $urandom_range(9)));
  endfunction

  function automatic void gen_string();
    int r;
    logic [7:0] b;
    put(CH_QUOTE);
    repeat ($urandom_range(5)) begin
      r = $urandom_range(19);
      if (r < 12) begin
        b = 8'($urandom_range(255));
        if (b == CH_QUOTE || b == CH_BSLASH) b = "x";
        put(b);
      end else if (r < 16) begin
        put(CH_BSLASH);
        case ($urandom_range(7))
          0: put(CH_QUOTE);
          1: put(CH_BSLASH);
          2: put("/");
          3: put("b");
          4: put("f");
          5: put("n");
          6: put("r");
          default: put("t");
        endcase
      end else if (r < 19) begin
        // The four bytes after the u are skipped, so anything may stand there.
        put(CH_BSLASH);
        put("u");
        repeat (4) put(8'($urandom_range(255)));
      end else begin
        put(CH_BSLASH);
        put(8'($urandom_range(255)));
      end
    end
    put(CH_QUOTE);
  endfunction

  function automatic void gen_number();
    bit minus;
    minus = 1'($urandom_range(1));
    if (minus) put("-");
    if ($urandom_range(11) == 0) put_digits($urandom_range(55, 70));
    else put_digits($urandom_range(minus ? 0 : 1, 3));
    if ($urandom_range(3) == 0) begin
      put(".");
      put_digits($urandom_range(2));
    end
    if ($urandom_range(3) == 0) begin
      put($urandom_range(1) ? "e" : "E");
      case ($urandom_range(2))
        0: put("+");
        1: put("-");
        default: ;
      endcase
      put_digits($urandom_range(2));
    end
  endfunction

  function automatic void gen_member_value(int max_depth);
    int pick;
    pick = $urandom_range((gen_left.size() < max_depth) ? 6 : 4);
    case (pick)
      0: begin
        case ($urandom_range(2))
          0: put_text("null");
          1: put_text("true");
          default: put_text("false");
        endcase
      end
      1, 2: gen_number();
      3, 4: gen_string();
      default: begin
        put(pick == 6 ? "{" : "[");
        put_ws();
        gen_is_obj.push_back(pick == 6);
        gen_left.push_back($urandom_range(3));
        gen_first.push_back(1'b1);
      end
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    string json_chars;
    json_chars = "[]{},:\"0-e.tn\\ ";
    if ($urandom_range(1)) return 8'($urandom_range(255));
    return json_chars[$urandom_range(json_chars.len() - 1)];
  endfunction

  // Mostly well-formed documents with random content; the rest is noise or damaged text.
  function automatic void gen_document();
    int style;
    int top;
    int pos;
    doc_text.delete();
    style = $urandom_range(99);
    if (style < 10) begin
      repeat ($urandom_range(1, 8)) put(noise_byte());
      return;
    end
    put_ws();
    gen_member_value($urandom_range(1, 4));
    while (gen_left.size() != 0) begin
      top = gen_left.size() - 1;
      if (gen_left[top] == 0) begin
        put_ws();
        put(gen_is_obj[top] ? "}" : "]");
        void'(gen_left.pop_back());
        void'(gen_is_obj.pop_back());
        void'(gen_first.pop_back());
      end else begin
        gen_left[top] = gen_left[top] - 1;
        if (!gen_first[top]) begin
          put(",");
          put_ws();
        end
        gen_first[top] = 1'b0;
        if (gen_is_obj[top]) begin
          gen_string();
          put_ws();
          put(":");
          put_ws();
        end
        gen_member_value(4);
      end
    end
    put_ws();
    if (style < 30) begin
      pos = $urandom_range(doc_text.size() - 1);
      case ($urandom_range(3))
        0: doc_text[pos] = 8'($urandom_range(255));
        1: if (doc_text.size() > 1) doc_text.delete(pos);
        2: while (doc_text.size() > pos + 1) void'(doc_text.pop_back());
        default: doc_text.insert(pos, ",");
      endcase
    end
  endfunction

  // Sender side. Each call starts right after a rising edge.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (!sender_calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    track_byte(b, lst);
  endtask

  task automatic send_doc();
    for (int i = 0; i < doc_text.size(); i++) send_byte(doc_text[i], i == doc_text.size() - 1);
    docs_sent++;
  endtask

  task automatic send_text(string s);
    doc_text.delete();
    put_text(s);
    send_doc();
  endtask

  // Nested containers alternating array and object around a single number.
  task automatic send_nest(int levels);
    doc_text.delete();
    for (int i = 0; i < levels; i++) begin
      if (i % 2) put_text("{\"k\":");
      else put("[");
    end
    put("0");
    for (int i = levels - 1; i >= 0; i--) put((i % 2) ? "}" : "]");
    send_doc();
  endtask

  task automatic send_number(int chars);
    doc_text.delete();
    put("1");
    put_digits(chars - 1);
    send_doc();
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle; both registers are written, the depth limit first.
  task automatic set_limits(input logic [8:0] depth, input logic [7:0] numlen);
    cfg_we <= 1'b1;
    cfg_index <= REG_DEPTH_LIMIT;
    cfg_data <= depth;
    @(posedge clk);
    cfg_index <= REG_NUMBER_LENGTH_LIMIT;
    cfg_data <= {1'b0, numlen};
    depth_limit = depth;
    @(posedge clk);
    cfg_we <= 1'b0;
    num_limit = numlen;
  endtask

  task automatic test_directed();
    send_text("null");
    send_text("true");
    send_text("false");
    send_text("-12.5e+3");
    send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\tz\\u12\"}x\"");
    send_text("{\"k\": [1, 2.0, {}], \"s\": \"v\"} ");
    send_text("[ ]");
    send_text("[1,]");
    send_text("{\"a\" 1}");
    send_text("{\"a\":1,}");
    send_text("nul");
    send_text("\"abc");
    send_text("1 2");
    send_text("-");
    send_text("1.");
    send_text("1e");
    send_text("[");
    send_text("\"\\x\"");
    send_text("{1:2}");
    send_text("[1]]");
    // Everything after the first bad byte is ignored until the end of the document.
    send_text("x]]]");
    send_text("[}");
    doc_text.delete();
    put(CH_QUOTE);
    put(8'hFF);
    put(8'h00);
    put(8'h80);
    put(CH_QUOTE);
    send_doc();
    doc_text.delete();
    put(8'h00);
    send_doc();
    doc_text.delete();
    put(8'h20);
    put(8'h09);
    put(8'h0A);
    put(8'h0D);
    put("7");
    put(8'h0D);
    send_doc();
  endtask

  task automatic test_depth_limit();
    wait_results();
    set_limits(9'd0, NUM_LIMIT_RESET);
    send_text("[]");
    send_text("5");
    send_text("\"s\"");
    wait_results();
    set_limits(9'd1, NUM_LIMIT_RESET);
    send_nest(1);
    send_nest(2);
    wait_results();
    set_limits(9'd3, NUM_LIMIT_RESET);
    send_nest(3);
    send_nest(4);
    wait_results();
    set_limits(DEPTH_LIMIT_RESET, NUM_LIMIT_RESET);
    send_nest(6);
  endtask

  task automatic test_number_limit();
    wait_results();
    set_limits(DEPTH_LIMIT_RESET, 8'd0);
    send_text("0");
    send_text("[]");
    wait_results();
    set_limits(DEPTH_LIMIT_RESET, 8'd1);
    send_text("7");
    wait_results();
    set_limits(DEPTH_LIMIT_RESET, 8'd2);
    send_text("7");
    send_text("-7");
    send_text("[7,8]");
    wait_results();
    set_limits(DEPTH_LIMIT_RESET, 8'd8);
    send_number(7);
    send_number(8);
    wait_results();
    set_limits(DEPTH_LIMIT_RESET, NUM_LIMIT_RESET);
    send_number(63);
    send_number(64);
  endtask

  // The receiver stops long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    wait_results();
    sender_calm = 1'b1;
    hold_left = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_text("[]");
      else send_text("9");
    end
    sender_calm = 1'b0;
    wait_results();
  endtask

  task automatic run_random_phase(input logic [8:0] depth, input logic [7:0] numlen,
                                  input bit calm);
    int bytes_start;
    int docs_start;
    wait_results();
    set_limits(depth, numlen);
    sender_calm = calm;
    sink_calm = calm;
    bytes_start = bytes_sent;
    docs_start = docs_sent;
    while (bytes_sent - bytes_start < 25 || docs_sent - docs_start < 3) begin
      gen_document();
      send_doc();
    end
    sender_calm = 1'b0;
    sink_calm = 1'b0;
  endtask

  task automatic test_random();
    run_random_phase(DEPTH_LIMIT_RESET, NUM_LIMIT_RESET, 1'b0);
    run_random_phase(9'd3, 8'd6, 1'b0);
    run_random_phase(9'd2, 8'd255, 1'b1);
    run_random_phase(9'd511, 8'd20, 1'b0);
  endtask

  initial begin
    int guard;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_depth_limit();
    test_number_limit();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    guard = 0;
    while (verdicts_due.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      $display("%0d verdicts never arrived", verdicts_due.size());
      error_count += verdicts_due.size();
    end
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/jsv_pkg.sv
hw/rtl/jsv_front.sv
hw/rtl/jsv_queue.sv
hw/rtl/jsv_back.sv
hw/rtl/json_syntax_validator.sv
dv/testbench.sv
